>>> sv/rlpm_pkg.sv
// Shared types and constants for the longest-prefix-match route lookup.
// Depends on nothing; every other file of the block uses it by scoped names.
package rlpm_pkg;

    // Field widths of the channel payloads and the configuration register.
    localparam int DATA_W    = 32;
    localparam int SLOT_W    = 6;
    localparam int LEN_W     = 6;
    localparam int ENTRIES_W = 7;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Command codes carried by an input transaction.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Register index taken from paddr[2].
    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    // One route table entry as it sits in the table memory.
    typedef struct packed {
        logic [DATA_W-1:0] dest;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] iface;
        logic [DATA_W-1:0] metric;
    } t_route;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    // Controls from the controller to the match unit.
    typedef struct packed {
        logic clear;
        logic ent_vld;
    } t_best_ctl;

    // Status and current winner from the match unit.
    typedef struct packed {
        logic              busy;
        logic              found;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] iface;
    } t_best_stat;

endpackage

>>> sv/rlpm_ifs.sv
// Valid/ready channel interfaces for lookup requests and lookup results.
// Depends on rlpm_pkg for the field widths.
interface rlpm_req_if;
    logic                            valid;
    logic                            ready;
    logic                            cmd;
    logic [rlpm_pkg::SLOT_W-1:0]     entry_slot;
    logic [rlpm_pkg::DATA_W-1:0]     route_dest;
    logic [rlpm_pkg::DATA_W-1:0]     route_mask;
    logic [rlpm_pkg::DATA_W-1:0]     route_iface;
    logic [rlpm_pkg::DATA_W-1:0]     route_metric;
    logic [rlpm_pkg::DATA_W-1:0]     lookup_addr;

    modport source (
        output valid, cmd, entry_slot, route_dest, route_mask, route_iface,
               route_metric, lookup_addr,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_slot, route_dest, route_mask, route_iface,
               route_metric, lookup_addr,
        output ready
    );
endinterface

interface rlpm_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            route_found;
    logic [rlpm_pkg::LEN_W-1:0]      match_prefix_len;
    logic [rlpm_pkg::DATA_W-1:0]     out_iface_index;

    modport source (
        output valid, route_found, match_prefix_len, out_iface_index,
        input  ready
    );
    modport sink (
        input  valid, route_found, match_prefix_len, out_iface_index,
        output ready
    );
endinterface

>>> sv/route_longest_prefix_lookup.sv
// Longest-prefix-match route lookup: route table memory, scan controller and
// configuration port. Depends on rlpm_pkg, rlpm_ifs and rlpm_best.
// A write transaction stores the entry at its acceptance.
// A lookup scans N = min(entries_in_use, TABLE_DEPTH) entries, one table read a
// cycle, through the table read register, the match stage and the winner
// registers to the output register; no new transaction is taken until the result
// is loaded, and the load waits while an earlier result is held for o_rsp.ready.
// Synchronous active-low reset clears control state; the table is not cleared.
module route_longest_prefix_lookup #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rlpm_req_if.sink                        i_req,
    rlpm_rsp_if.source                      o_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rlpm_pkg::PADDR_W-1:0]    paddr,
    input  logic [rlpm_pkg::PDATA_W-1:0]    pwdata,
    output logic [rlpm_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LW = $clog2(TABLE_DEPTH + 1);

    rlpm_pkg::t_state                    r_state, n_state;
    logic [AW-1:0]                       r_idx;
    logic [LW-1:0]                       r_limit;
    logic [rlpm_pkg::DATA_W-1:0]         r_addr;
    logic [rlpm_pkg::ENTRIES_W-1:0]      r_entries;
    rlpm_pkg::t_route                    r_mem [TABLE_DEPTH];
    rlpm_pkg::t_route                    r_rd_data;
    logic                                r_rd_vld;
    logic                                r_out_vld;
    logic                                r_out_found;
    logic [rlpm_pkg::LEN_W-1:0]          r_out_len;
    logic [rlpm_pkg::DATA_W-1:0]         r_out_iface;

    logic                                w_in_ready;
    logic                                w_rd_en;
    logic                                w_out_load;
    logic                                w_accept;
    logic                                w_lookup;
    logic                                w_wr_en;
    logic [AW-1:0]                       w_wr_addr;
    logic [LW-1:0]                       w_limit;
    logic                                w_last;
    logic                                w_cfg_wr;
    rlpm_pkg::t_best_ctl                 w_ctl;
    rlpm_pkg::t_best_stat                w_best;

    // Input transaction decode.
    assign w_accept  = i_req.valid && w_in_ready;
    assign w_lookup  = w_accept && (i_req.cmd == rlpm_pkg::CMD_LOOKUP);
    assign w_wr_en   = w_accept && (i_req.cmd == rlpm_pkg::CMD_WRITE) &&
                       (32'(i_req.entry_slot) < TABLE_DEPTH);
    assign w_wr_addr = AW'(i_req.entry_slot);

    // Scan length saturates at the table depth.
    always_comb begin
        if (32'(r_entries) > TABLE_DEPTH) begin
            w_limit = LW'(TABLE_DEPTH);
        end else begin
            w_limit = LW'(r_entries);
        end
    end

    assign w_last = (LW'(r_idx) + LW'(1)) == r_limit;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rlpm_pkg::ST_IDLE: begin
                if (w_lookup) begin
                    n_state = (w_limit == '0) ? rlpm_pkg::ST_DRAIN : rlpm_pkg::ST_SCAN;
                end
            end
            rlpm_pkg::ST_SCAN: begin
                if (w_last) begin
                    n_state = rlpm_pkg::ST_DRAIN;
                end
            end
            rlpm_pkg::ST_DRAIN: begin
                if (w_out_load) begin
                    n_state = rlpm_pkg::ST_IDLE;
                end
            end
            default: n_state = rlpm_pkg::ST_IDLE;
        endcase
    end

    // State outputs: the result is loaded once the match pipeline has emptied
    // and the output register is free or being emptied.
    always_comb begin
        w_in_ready = 1'b0;
        w_rd_en    = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            rlpm_pkg::ST_IDLE:  w_in_ready = 1'b1;
            rlpm_pkg::ST_SCAN:  w_rd_en    = 1'b1;
            rlpm_pkg::ST_DRAIN: w_out_load = !r_rd_vld && !w_best.busy &&
                                             (!r_out_vld || o_rsp.ready);
            default: ;
        endcase
    end

    // Controller registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rlpm_pkg::ST_IDLE;
            r_idx    <= '0;
            r_limit  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_rd_en;
            if (w_lookup) begin
                r_idx   <= '0;
                r_limit <= w_limit;
            end else if (w_rd_en) begin
                r_idx <= r_idx + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lookup) begin
            r_addr <= i_req.lookup_addr;
        end
    end

    // Route table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= '{dest:   i_req.route_dest,
                                  mask:   i_req.route_mask,
                                  iface:  i_req.route_iface,
                                  metric: i_req.route_metric};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // Match and winner selection.
    assign w_ctl = '{clear: w_lookup, ent_vld: r_rd_vld};

    rlpm_best u_best (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_entry (r_rd_data),
        .i_addr  (r_addr),
        .o_stat  (w_best)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_found <= w_best.found;
            r_out_len   <= w_best.found ? w_best.len : '0;
            r_out_iface <= w_best.found ? w_best.iface : '0;
        end
    end

    assign i_req.ready            = w_in_ready;
    assign o_rsp.valid            = r_out_vld;
    assign o_rsp.route_found      = r_out_found;
    assign o_rsp.match_prefix_len = r_out_len;
    assign o_rsp.out_iface_index  = r_out_iface;

    // Configuration port: single register, writes complete in the access cycle.
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
        end else if (w_cfg_wr && (paddr[2] == rlpm_pkg::REG_ENTRIES_IN_USE)) begin
            r_entries <= pwdata[rlpm_pkg::ENTRIES_W-1:0];
        end
    end

    assign prdata = (paddr[2] == rlpm_pkg::REG_ENTRIES_IN_USE) ?
                    rlpm_pkg::PDATA_W'(r_entries) : '0;
    assign pready = 1'b1;

    // Table reads arrive only as the result of a scan cycle.
    a_rd_from_scan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state == rlpm_pkg::ST_SCAN))
        else $error("table read data without a scan cycle");

    // The scan index stays inside the scanned range.
    a_idx_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rlpm_pkg::ST_SCAN) |-> (LW'(r_idx) < r_limit))
        else $error("scan index beyond the scan length");

    // A result is loaded only after the match pipeline has drained.
    a_load_drained : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_rd_vld && !w_best.busy && !w_rd_en))
        else $error("result loaded while entries are still in flight");

    // A result without a route carries zero length and interface.
    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.route_found) |->
            ((o_rsp.match_prefix_len == '0) && (o_rsp.out_iface_index == '0)))
        else $error("miss result carries nonzero route fields");

endmodule

>>> sv/rlpm_best.sv
// Match unit: compares one table entry a cycle against the lookup address
// and keeps the best route so far. Depends on rlpm_pkg.
module rlpm_best (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rlpm_pkg::t_best_ctl           i_ctl,
    input  rlpm_pkg::t_route              i_entry,
    input  logic [rlpm_pkg::DATA_W-1:0]   i_addr,
    output rlpm_pkg::t_best_stat          o_stat
);

    // Count of leading one bits from bit 31, found by a five-step halving search.
    function automatic logic [rlpm_pkg::LEN_W-1:0] f_lead_ones(
        input logic [rlpm_pkg::DATA_W-1:0] m
    );
        logic [rlpm_pkg::DATA_W-1:0] v;
        logic [rlpm_pkg::LEN_W-1:0]  n;
        v = m;
        n = '0;
        if (&v[31:16]) begin
            n = n + 6'd16;
            v = v << 16;
        end
        if (&v[31:24]) begin
            n = n + 6'd8;
            v = v << 8;
        end
        if (&v[31:28]) begin
            n = n + 6'd4;
            v = v << 4;
        end
        if (&v[31:30]) begin
            n = n + 6'd2;
            v = v << 2;
        end
        if (v[31]) begin
            n = n + 6'd1;
        end
        if (&m) begin
            n = 6'd32;
        end
        return n;
    endfunction

    logic                          r_a_vld;
    logic                          r_a_hit;
    logic [rlpm_pkg::LEN_W-1:0]    r_a_len;
    logic [rlpm_pkg::DATA_W-1:0]   r_a_iface;
    logic [rlpm_pkg::DATA_W-1:0]   r_a_metric;

    logic                          r_found;
    logic [rlpm_pkg::LEN_W-1:0]    r_len;
    logic [rlpm_pkg::DATA_W-1:0]   r_iface;
    logic [rlpm_pkg::DATA_W-1:0]   r_metric;

    logic                          w_take;

    // First stage: match test and prefix length of the entry just read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_ctl.ent_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_hit    <= (i_entry.dest == '0) ||
                      ((i_addr & i_entry.mask) == (i_entry.dest & i_entry.mask));
        r_a_len    <= f_lead_ones(i_entry.mask);
        r_a_iface  <= i_entry.iface;
        r_a_metric <= i_entry.metric;
    end

    // A matching entry wins when it is the first match, has a longer prefix,
    // or has the same prefix with a strictly lower metric.
    assign w_take = r_a_vld && r_a_hit &&
                    (!r_found || (r_a_len > r_len) ||
                     ((r_a_len == r_len) && (r_a_metric < r_metric)));

    // Second stage: winner registers, cleared when a lookup is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_len    <= '0;
            r_iface  <= '0;
            r_metric <= '0;
        end else if (w_take) begin
            r_len    <= r_a_len;
            r_iface  <= r_a_iface;
            r_metric <= r_a_metric;
        end
    end

    assign o_stat = '{busy: r_a_vld, found: r_found, len: r_len, iface: r_iface};

endmodule
